/* hdl/htw_pkg.sv */
// ============================================================================
// htw_pkg: shared definitions for the hashed timing wheel
// Sizes, transaction types, ring entry layout, codes and slot arithmetic.
// ============================================================================
`default_nettype none

package htw_pkg;

  // Wheel geometry.
  localparam int SLOTS  = 60;
  localparam int TASKS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;

  // Field widths.
  localparam int ACT_W  = 2;
  localparam int ID_W   = 5;
  localparam int IVL_W  = 20;
  localparam int CNT_W  = 16;
  localparam int KIND_W = 2;
  // Width that holds any entry index as well as any task_id value.
  localparam int CMP_W  = ID_W + 1;

  // Remainder by SLOTS through a scaled reciprocal. The rounding error of
  // MOD_RECIP is below 2**SLOT_W, so for every interval below 2**IVL_W the
  // top bits of interval * MOD_RECIP are the exact quotient.
  localparam int MOD_SHIFT   = IVL_W + SLOT_W;
  localparam int MOD_RECIP_W = IVL_W + 1;
  localparam int MOD_PROD_W  = IVL_W + MOD_RECIP_W;
  localparam int MOD_QUO_W   = MOD_PROD_W - MOD_SHIFT;
  localparam logic [MOD_RECIP_W-1:0] MOD_RECIP =
    MOD_RECIP_W'(((64'd1 << MOD_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  // Response kinds.
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [ID_W-1:0]         task_id;
    logic [IVL_W-1:0]        interval;
    logic signed [CNT_W-1:0] repeat_count;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic              status;
    logic              freed;
    logic              last;
  } rsp_t;

  // One timer entry as it travels around the ring of cells.
  typedef struct packed {
    logic                    armed;
    logic [SLOT_W-1:0]       due;
    logic [IVL_W-1:0]        remaining;
    logic [IVL_W-1:0]        period;
    logic [SLOT_W-1:0]       phase;     // period mod SLOTS
    logic signed [CNT_W-1:0] count;
  } entry_t;

  // Remainder unit handshake.
  typedef struct packed {
    logic             start;
    logic [IVL_W-1:0] value;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] result;
  } mod_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Sum of two slot numbers, wrapped around the wheel.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SLOT_W+1)'(SLOTS)) begin
      sum = sum - (SLOT_W+1)'(SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/htw_mod.sv */
// ============================================================================
// htw_mod: remainder by the wheel size
// Reduces an interval modulo SLOTS in two stages through a reciprocal.
// ============================================================================
`default_nettype none

module htw_mod (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire htw_pkg::mod_req_t mreq,
  output htw_pkg::mod_rsp_t      mrsp
);
  import htw_pkg::*;

  logic [MOD_PROD_W-1:0] prod;
  logic [MOD_QUO_W-1:0]  quo;
  logic [IVL_W-1:0]      ivl_q;
  logic [IVL_W-1:0]      back;
  logic [SLOT_W-1:0]     rem;
  logic                  pend;

  // First stage: quotient from the scaled reciprocal of SLOTS.
  assign prod = MOD_PROD_W'(mreq.value) * MOD_PROD_W'(MOD_RECIP);

  // Second stage: the remainder is what the quotient leaves of the interval.
  assign back = IVL_W'(quo) * IVL_W'(SLOTS);

  // The second stage runs in the cycle after a start.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= mreq.start;
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (mreq.start) begin
      quo   <= prod[MOD_PROD_W-1:MOD_SHIFT];
      ivl_q <= mreq.value;
    end
    if (pend) begin
      rem <= SLOT_W'(ivl_q - back);
    end
  end

  assign mrsp.busy   = pend;
  assign mrsp.result = rem;

endmodule

`default_nettype wire

/* hdl/htw_cell.sv */
// ============================================================================
// htw_cell: one timer entry of the ring
// Holds an entry and takes its neighbor's entry whenever the ring advances.
// ============================================================================
`default_nettype none

module htw_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire htw_pkg::entry_t d,
  output htw_pkg::entry_t      q
);
  import htw_pkg::*;

  entry_t ent;

  // The armed flag is the only part of an entry with a reset value; the
  // rest is meaningful only while the entry is armed.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.armed <= 1'b0;
    end else if (shift) begin
      ent.armed <= d.armed;
    end
    if (shift) begin
      ent.due       <= d.due;
      ent.remaining <= d.remaining;
      ent.period    <= d.period;
      ent.phase     <= d.phase;
      ent.count     <= d.count;
    end
  end

  assign q = ent;

endmodule

`default_nettype wire

/* hdl/htw_ctrl.sv */
// ============================================================================
// htw_ctrl: sequencer and entry service for the timing wheel
// Runs each tick, and each add or remove of a valid entry, as one full turn of the
// cell ring, updates the entry at the head of the ring and drives the response register.
// ============================================================================
`default_nettype none

module htw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire htw_pkg::req_t     req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output htw_pkg::rsp_t          rsp,
  input  wire htw_pkg::entry_t   head,
  output htw_pkg::entry_t        tail,
  output logic                   shift,
  output htw_pkg::mod_req_t      mreq,
  input  wire htw_pkg::mod_rsp_t mrsp
);
  import htw_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [SLOT_W-1:0]       cur_slot;
  logic [ACT_W-1:0]        op;
  logic [ID_W-1:0]         tid;
  logic [IVL_W-1:0]        ivl;
  logic signed [CNT_W-1:0] cnt_in;
  logic [IDX_W-1:0]        idx;
  logic                    found;
  logic                    accept;
  logic                    out_free;
  logic                    id_ok;
  logic                    req_id_ok;
  logic                    match;
  logic                    last_idx;
  logic                    fire;
  logic                    fire_freed;
  logic                    emit;
  logic signed [CNT_W-1:0] cnt_dec;
  rsp_t                    rsp_next;

  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign id_ok     = {1'b0, tid} < CMP_W'(TASKS);
  assign req_id_ok = {1'b0, req.task_id} < CMP_W'(TASKS);
  assign match     = CMP_W'(idx) == {1'b0, tid};
  assign last_idx  = idx == IDX_W'(TASKS - 1);

  // Remainder unit starts on every accepted add.
  assign mreq.start = accept && (req.action == ACT_ADD);
  assign mreq.value = req.interval;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_ADD:    state_next = req_id_ok ? ST_MOD : ST_DONE;
            ACT_REMOVE: state_next = req_id_ok ? ST_SCAN : ST_DONE;
            ACT_TICK:   state_next = ST_SCAN;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        if (!mrsp.busy) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free && last_idx) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Service of the entry at the head of the ring.
  always_comb begin
    tail       = head;
    fire       = 1'b0;
    fire_freed = 1'b0;
    cnt_dec    = head.count;
    case (op)
      ACT_ADD: begin
        if (match) begin
          tail.armed     = 1'b1;
          tail.due       = slot_add(cur_slot, (ivl == '0) ? SLOT_W'(1) : mrsp.result);
          tail.remaining = ivl;
          tail.period    = ivl;
          tail.phase     = mrsp.result;
          tail.count     = cnt_in;
        end
      end
      ACT_REMOVE: begin
        if (match) begin
          tail.armed = 1'b0;
        end
      end
      ACT_TICK: begin
        if (head.armed && (head.due == cur_slot)) begin
          if (head.remaining > IVL_W'(SLOTS)) begin
            // Another round of the wheel to go.
            tail.remaining = head.remaining - IVL_W'(SLOTS);
          end else begin
            fire = 1'b1;
            if (!head.count[CNT_W-1] && (head.count != '0)) begin
              cnt_dec = head.count - CNT_W'(1);
            end
            tail.count = cnt_dec;
            if (cnt_dec == '0) begin
              tail.armed = 1'b0;
              fire_freed = 1'b1;
            end else begin
              tail.due       = slot_add(cur_slot, head.phase);
              tail.remaining = head.period;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req_stall = (state != ST_IDLE);
    shift     = (state == ST_SCAN) && out_free;
    emit      = 1'b0;
    rsp_next  = '0;
    case (state)
      ST_SCAN: begin
        emit              = out_free && fire;
        rsp_next.kind     = KIND_FIRED;
        rsp_next.fired_id = ID_W'(idx);
        rsp_next.freed    = fire_freed;
      end
      ST_DONE: begin
        rsp_next.last = 1'b1;
        case (op)
          ACT_ADD: begin
            emit              = out_free;
            rsp_next.kind     = KIND_ACK;
            rsp_next.fired_id = tid;
            rsp_next.status   = !id_ok;
          end
          ACT_REMOVE: begin
            emit              = out_free;
            rsp_next.kind     = KIND_ACK;
            rsp_next.fired_id = tid;
            rsp_next.status   = !(id_ok && found);
          end
          ACT_TICK: begin
            emit          = out_free;
            rsp_next.kind = KIND_DONE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Request registers and wheel position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
    end else if (accept && (req.action == ACT_TICK)) begin
      cur_slot <= slot_add(cur_slot, SLOT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.action;
      tid    <= req.task_id;
      ivl    <= req.interval;
      cnt_in <= req.repeat_count;
    end
  end

  // Ring position and the armed state seen by a remove.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (accept) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (shift) begin
      idx <= last_idx ? '0 : idx + IDX_W'(1);
      if (match) begin
        found <= head.armed;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/hashed_timing_wheel.sv */
// ============================================================================
// hashed_timing_wheel: hashed timing wheel with a table of timer entries
// Add, remove and tick requests in; acknowledges, firings and tick-done out.
// ============================================================================
// The timer entries live in a ring of TASKS cells that turns by one place
// per cycle while a request is served and the response side is not stalled;
// the entry at the head of the ring is updated and written back at the tail,
// so entries are visited, and fire, in ascending index order. Every tick and
// every add or remove that names a valid entry takes one full turn; an add
// first reduces the interval modulo SLOTS in a two-stage reciprocal-multiply
// remainder unit. An add or remove of an index beyond the table, or an
// unknown action, skips the turn. The ring pauses whenever the response
// register is full and stalled. A tick returns one firing per due entry and
// then a tick-done response.
`default_nettype none

module hashed_timing_wheel (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire htw_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output htw_pkg::rsp_t      rsp
);
  import htw_pkg::*;

  entry_t   ring_q [TASKS];
  entry_t   tail;
  logic     shift;
  mod_req_t mreq;
  mod_rsp_t mrsp;

  // Sequencer and entry service.
  htw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .head      (ring_q[0]),
    .tail      (tail),
    .shift     (shift),
    .mreq      (mreq),
    .mrsp      (mrsp)
  );

  // Interval remainder for adds.
  htw_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .mreq (mreq),
    .mrsp (mrsp)
  );

  // Ring of entry cells: each takes its upper neighbor, the last takes the
  // serviced head entry.
  for (genvar k = 0; k < TASKS; k++) begin : g_cell
    if (k == TASKS - 1) begin : g_tail
      htw_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (tail),
        .q     (ring_q[k])
      );
    end else begin : g_mid
      htw_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (ring_q[k+1]),
        .q     (ring_q[k])
      );
    end
  end

endmodule

`default_nettype wire

/* hdl/htw_chk.sv */
// ============================================================================
// htw_chk: port checker for the hashed timing wheel
// Watches the request and response channels of the top level over time.
// ============================================================================
`default_nettype none

module htw_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire htw_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire htw_pkg::rsp_t rsp
);
  import htw_pkg::*;

  // A request is served alone: the channel closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another was in progress");

  // A stalled request holds.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Firings are never the final response of a request; all others are.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.last == (rsp.kind != KIND_FIRED)))
    else $error("last flag does not match response kind");

  // A firing names an entry of the table and carries no error.
  a_fired_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_FIRED) |->
      !rsp.status && ({1'b0, rsp.fired_id} < CMP_W'(TASKS)))
    else $error("firing reported for an invalid entry");

endmodule

bind hashed_timing_wheel htw_chk u_htw_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
